FILE: hw/rtl/box_filter_3x3_stream_macros.svh
// Assertion macros for the box filter RTL.
`ifndef BOX_FILTER_3X3_STREAM_MACROS_SVH
`define BOX_FILTER_3X3_STREAM_MACROS_SVH
`ifndef SYNTH
`define BF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box filter assertion failed");
`define BF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box filter assertion failed");
`else
`define BF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/bf3_pkg.sv
`default_nettype none
package bf3_pkg;

  localparam int PIX_W      = 16;
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CS_W       = PIX_W + 2;
  localparam int SUM_W      = PIX_W + 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int CFG_RESET_WIDTH  = 128;
  localparam int CFG_RESET_HEIGHT = 128;

  // Division by nine is a multiplication by ceil(2^23 / 9), exact for sums below 2^21.
  localparam int               RECIP_SHIFT = 23;
  localparam int               RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP     = 20'd932068;
  localparam int               MULT_W      = SUM_W + RECIP_W;
  localparam logic [SUM_W-1:0] MEAN_ROUND  = 20'd4;

  localparam int NUM_SLOTS      = 4;
  localparam int SLOT_CENTER    = 0;
  localparam int SLOT_ROW_END   = 1;
  localparam int SLOT_LAST_ROW  = 2;
  localparam int SLOT_FRAME_END = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [SUM_W-1:0]     sum4;
    logic                 center_mean;
    logic [PIX_W-1:0]     p11;
    logic [PIX_W-1:0]     p12;
    logic [PIX_W-1:0]     p21;
    logic [PIX_W-1:0]     p22;
    logic [NUM_SLOTS-1:0] emit;
  } bf3_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bf3_qstat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bf3_front.sv
`default_nettype none
module bf3_front
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel,
  input  wire bf3_qstat_t            q_stat,
  output logic                       push,
  output bf3_job_t                   job
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int W_RST = (MAX_WIDTH < CFG_RESET_WIDTH) ? MAX_WIDTH : CFG_RESET_WIDTH;

  logic [WW-1:0]         width_r;
  logic [CFG_H_BITS-1:0] height_r;
  logic [CFG_W_BITS-1:0] cfg_w;
  logic [AW-1:0]         col_r, col_nxt, col_cur;
  logic [CFG_H_BITS-1:0] row_r, row_nxt, row_cur;
  logic                  col_last, row_last;
  logic                  in_fire;

  logic                  s1_valid_r;
  logic [PIX_W-1:0]      s1_px_r;
  logic [AW-1:0]         s1_col_r;
  logic [NUM_SLOTS-1:0]  s1_emit_r, emit_now;
  logic                  s1_mean_r, mean_now;
  logic                  s1_adv;

  logic [2*PIX_W-1:0]    line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]    line_rd_r, fwd_data_r, line_eff;
  logic                  fwd_r;
  logic [PIX_W-1:0]      above2, above1;
  logic [CS_W-1:0]       cs_new;

  logic                  s2_valid_r, s2_free;
  logic [NUM_SLOTS-1:0]  s2_emit_r;
  logic                  s2_mean_r;
  logic [CS_W-1:0]       cs0_r, cs1_r, cs2_r;
  logic [PIX_W-1:0]      p11_r, p12_r, p21_r, p22_r;

  assign cfg_w = cfg_wdata[CFG_W_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(W_RST);
      height_r <= CFG_H_BITS'(CFG_RESET_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        if (cfg_w == '0) begin
          width_r <= WW'(1);
        end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
          width_r <= WW'(MAX_WIDTH);
        end else begin
          width_r <= WW'(cfg_w);
        end
      end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
        height_r <= (cfg_wdata[CFG_H_BITS-1:0] == '0) ? CFG_H_BITS'(1)
                                                      : cfg_wdata[CFG_H_BITS-1:0];
      end
    end
  end

  assign col_cur  = (WW'(col_r) >= width_r) ? '0 : col_r;
  assign row_cur  = (row_r >= height_r) ? '0 : row_r;
  assign col_last = (WW'(col_cur) + WW'(1)) == width_r;
  assign row_last = (row_cur + CFG_H_BITS'(1)) == height_r;

  always_comb begin
    emit_now                 = '0;
    emit_now[SLOT_CENTER]    = (row_cur != '0) && (col_cur != '0);
    emit_now[SLOT_ROW_END]   = (row_cur != '0) && col_last;
    emit_now[SLOT_LAST_ROW]  = row_last && (col_cur != '0);
    emit_now[SLOT_FRAME_END] = row_last && col_last;
    mean_now = (row_cur[CFG_H_BITS-1:1] != '0) && (col_cur[AW-1:1] != '0);
    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : row_cur + CFG_H_BITS'(1);
    end else begin
      col_nxt = col_cur + AW'(1);
      row_nxt = row_cur;
    end
  end

  assign in_ready = !s1_valid_r || s2_free;
  assign in_fire  = in_valid && in_ready;
  assign s1_adv   = s1_valid_r && s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= in_pixel;
      s1_col_r  <= col_cur;
      s1_emit_r <= emit_now;
      s1_mean_r <= mean_now;
    end
  end

  // Each entry holds the two rows above: {row r-2, row r-1}.
  assign line_eff = fwd_r ? fwd_data_r : line_rd_r;
  assign above2   = line_eff[2*PIX_W-1:PIX_W];
  assign above1   = line_eff[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_rd_r <= line_mem[col_cur];
    end
    if (s1_adv) begin
      line_mem[s1_col_r] <= {above1, s1_px_r};
    end
  end

  // A read that meets the write of the same column takes the written word instead.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_r      <= s1_valid_r && (s1_col_r == col_cur);
      fwd_data_r <= {above1, s1_px_r};
    end
  end

  assign cs_new = CS_W'(above2) + CS_W'(above1) + CS_W'(s1_px_r);

  assign s2_free = !s2_valid_r || (s2_emit_r == '0) || !q_stat.full;
  assign push    = s2_valid_r && (s2_emit_r != '0) && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
    end else if (s2_free) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_emit_r <= s1_emit_r;
      s2_mean_r <= s1_mean_r;
      cs0_r     <= cs1_r;
      cs1_r     <= cs2_r;
      cs2_r     <= cs_new;
      p11_r     <= p12_r;
      p12_r     <= above1;
      p21_r     <= p22_r;
      p22_r     <= s1_px_r;
    end
  end

  always_comb begin
    job.sum4        = SUM_W'(cs0_r) + SUM_W'(cs1_r) + SUM_W'(cs2_r) + MEAN_ROUND;
    job.center_mean = s2_mean_r;
    job.p11         = p11_r;
    job.p12         = p12_r;
    job.p21         = p21_r;
    job.p22         = p22_r;
    job.emit        = s2_emit_r;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bf3_queue.sv
`default_nettype none
module bf3_queue
  import bf3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire bf3_job_t push_job,
  input  wire logic     pop,
  output bf3_job_t      head_job,
  output bf3_qstat_t    q_stat
);

  bf3_job_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign q_stat.full  = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign q_stat.empty = count_r == '0;
  assign head_job     = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bf3_back.sv
`default_nettype none
module bf3_back
  import bf3_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire bf3_job_t     head_job,
  input  wire bf3_qstat_t   q_stat,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [PIX_W-1:0]  out_pixel,
  output logic              out_is_border,
  output logic              out_frame_last
);

  logic [NUM_SLOTS-1:0] done_r, rem, pick, rest;
  logic                 load;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     pixel_r, pixel_nxt;
  logic                 border_r, border_nxt;
  logic                 last_r, last_nxt;
  logic [MULT_W-1:0]    prod;
  logic [PIX_W-1:0]     mean;

  assign rem  = head_job.emit & ~done_r;
  assign pick = rem & (~rem + NUM_SLOTS'(1));
  assign rest = rem & ~pick;
  assign load = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop  = load && (rest == '0);

  assign prod = MULT_W'(head_job.sum4) * MULT_W'(RECIP);
  assign mean = prod[RECIP_SHIFT +: PIX_W];

  always_comb begin
    pixel_nxt  = head_job.p22;
    border_nxt = 1'b1;
    last_nxt   = 1'b0;
    if (pick[SLOT_CENTER]) begin
      pixel_nxt  = head_job.center_mean ? mean : head_job.p11;
      border_nxt = !head_job.center_mean;
    end else if (pick[SLOT_ROW_END]) begin
      pixel_nxt = head_job.p12;
    end else if (pick[SLOT_LAST_ROW]) begin
      pixel_nxt = head_job.p21;
    end else begin
      last_nxt = pick[SLOT_FRAME_END];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r      <= pop ? '0 : (done_r | pick);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r  <= pixel_nxt;
      border_r <= border_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = pixel_r;
  assign out_is_border  = border_r;
  assign out_frame_last = last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/box_filter_3x3_stream.sv
// Streaming 3x3 mean filter over a raster-order frame of unsigned 16-bit pixels.
// Input words arrive on in_valid/in_ready; filtered words leave on out_valid/out_ready
// in raster order, each with a border flag and a flag on the last pixel of the frame.
// Frame width and height are set through cfg_we/cfg_index/cfg_wdata while the block
// is idle; both reset to 128.
// Pixel (r,c) is emitted once pixel (r+1,c+1) has been taken. The end of a row and
// the last row release border pixels directly, so one input word yields zero to four
// output words.
// The words of an input pass through the front-end stage registers, the queue and the output register.
// The front end takes one word per cycle while the queue has room, and the back end sends
// one word per cycle while the receiver is ready; one input word may yield several outputs.
// A four-entry queue between them absorbs bursts, and a stalled receiver fills it
// before in_ready drops. The output register keeps its word until it is taken.
// Reset clears the row and column position and the valid flags of every stage and the queue;
// the line buffer needs no clearing since the words it holds before the rows are written are never used.
`default_nettype none
`include "box_filter_3x3_stream_macros.svh"
module box_filter_3x3_stream
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           out_pixel_out,
  output logic                       out_is_border,
  output logic                       out_frame_last
);

  logic       q_push, q_pop;
  bf3_job_t   push_job, head_job;
  bf3_qstat_t q_stat;

  bf3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel_in),
    .q_stat   (q_stat),
    .push     (q_push),
    .job      (push_job)
  );

  bf3_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .head_job(head_job),
    .q_stat  (q_stat)
  );

  bf3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_job      (head_job),
    .q_stat        (q_stat),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel_out),
    .out_is_border (out_is_border),
    .out_frame_last(out_frame_last)
  );

  `BF3_ASSERT_IMP(a_no_overflow, clk, rst_n, q_push, !q_stat.full)
  `BF3_ASSERT_IMP(a_no_underflow, clk, rst_n, q_pop, !q_stat.empty)
  `BF3_ASSERT_IMP(a_last_is_border, clk, rst_n, out_valid && out_frame_last, out_is_border)
  `BF3_ASSERT_NXT(a_pop_loads_out, clk, rst_n, q_pop, out_valid)

endmodule
`default_nettype wire
